[src/lcdnb_pkg.sv]
// ----------------------------------------------------------------------------
// lcdnb_pkg
// shared types, codes and the init byte table of the lcd nibble bus sequencer
// ----------------------------------------------------------------------------
package lcdnb_pkg;

    localparam int INIT_STEPS_DEF = 6;
    localparam int INIT_IDX_W     = 3;
    localparam int TABLE_LEN      = 6;
    localparam int PHASES_MAX     = 11;
    localparam int PH_IDX_W       = 4;

    typedef enum logic [1:0] {
        FUNC_WRITE  = 2'd0,
        FUNC_INIT   = 2'd1,
        FUNC_SAMPLE = 2'd2
    } t_func;

    typedef enum logic {
        PH_IDLE = 1'b0,
        PH_WAIT = 1'b1
    } t_phase;

    // which phase script one accepted word runs
    typedef enum logic [1:0] {
        K_REJECT = 2'd0,
        K_START  = 2'd1,
        K_BUSY   = 2'd2,
        K_CLEAR  = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic       more;      // init continues with the next poll
        logic [7:0] wr_byte;
        logic       wr_sel;
        logic       rj_rs;
        logic       rj_rw;
        logic [3:0] rj_nib;
        logic       rj_drv;
    } t_script;

    typedef struct packed {
        logic       rs_pin;
        logic       rw_pin;
        logic       en_pin;
        logic [3:0] nibble_out;
        logic       d7_drive;
        logic       sample_request;
        logic       last;
        logic       rejected;
    } t_pins;

    typedef logic [7:0] t_init_tbl [TABLE_LEN];
    localparam t_init_tbl INIT_TABLE = '{8'h33, 8'h32, 8'h28, 8'h0C, 8'h06, 8'h01};

    // steps past the table end repeat clear display
    function automatic logic [7:0] table_byte(input logic [INIT_IDX_W-1:0] idx);
        logic [7:0] b;
        b = INIT_TABLE[TABLE_LEN-1];
        for (int k = 0; k < TABLE_LEN; k++) begin
            if (idx == INIT_IDX_W'(k)) begin
                b = INIT_TABLE[k];
            end
        end
        return b;
    endfunction

    function automatic logic [PH_IDX_W-1:0] script_len(input t_script s);
        logic [PH_IDX_W-1:0] n;
        case (s.kind)
            K_REJECT: n = PH_IDX_W'(1);
            K_START:  n = PH_IDX_W'(3);
            K_BUSY:   n = PH_IDX_W'(4);
            K_CLEAR:  n = s.more ? PH_IDX_W'(PHASES_MAX) : PH_IDX_W'(8);
            default:  n = PH_IDX_W'(1);
        endcase
        return n;
    endfunction

    // pin levels of phase idx within a script
    function automatic t_pins phase_gen(input t_script s, input logic [PH_IDX_W-1:0] idx);
        t_pins p;
        logic [PH_IDX_W-1:0] pos;
        p = '0;
        pos = idx;
        case (s.kind)
            K_REJECT: begin
                p.rs_pin     = s.rj_rs;
                p.rw_pin     = s.rj_rw;
                p.nibble_out = s.rj_nib;
                p.d7_drive   = s.rj_drv;
                p.rejected   = 1'b1;
            end
            K_START: begin
                p.rw_pin         = 1'b1;
                p.en_pin         = (pos == PH_IDX_W'(1));
                p.sample_request = (pos == PH_IDX_W'(2));
            end
            K_BUSY: begin
                p.rw_pin         = 1'b1;
                p.en_pin         = (pos == PH_IDX_W'(0)) || (pos == PH_IDX_W'(2));
                p.sample_request = (pos == PH_IDX_W'(3));
            end
            K_CLEAR: begin
                if (pos < PH_IDX_W'(2)) begin
                    // ignored low-nibble read pulse
                    p.rw_pin = 1'b1;
                    p.en_pin = (pos == PH_IDX_W'(0));
                end else if (pos < PH_IDX_W'(8)) begin
                    p.rs_pin     = s.wr_sel;
                    p.d7_drive   = 1'b1;
                    p.nibble_out = (pos < PH_IDX_W'(5)) ? s.wr_byte[7:4] : s.wr_byte[3:0];
                    p.en_pin     = (pos == PH_IDX_W'(3)) || (pos == PH_IDX_W'(6));
                end else begin
                    p.rw_pin         = 1'b1;
                    p.en_pin         = (pos == PH_IDX_W'(9));
                    p.sample_request = (pos == PH_IDX_W'(10));
                end
            end
            default: p = '0;
        endcase
        return p;
    endfunction

endpackage

[src/lcdnb_if.sv]
// ----------------------------------------------------------------------------
// lcdnb_if
// request and pin phase channels of the lcd nibble bus sequencer
// ----------------------------------------------------------------------------
interface lcdnb_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] data_byte;
    logic       reg_select;
    logic       busy_flag;

    modport source (output valid, output func, output data_byte, output reg_select,
                    output busy_flag, input ready);
    modport sink   (input valid, input func, input data_byte, input reg_select,
                    input busy_flag, output ready);
endinterface

interface lcdnb_pin_if;
    logic       valid;
    logic       ready;
    logic       rs_pin;
    logic       rw_pin;
    logic       en_pin;
    logic [3:0] nibble_out;
    logic       d7_drive;
    logic       sample_request;
    logic       last;
    logic       rejected;

    modport source (output valid, output rs_pin, output rw_pin, output en_pin,
                    output nibble_out, output d7_drive, output sample_request,
                    output last, output rejected, input ready);
    modport sink   (input valid, input rs_pin, input rw_pin, input en_pin,
                    input nibble_out, input d7_drive, input sample_request,
                    input last, input rejected, output ready);
endinterface

[src/lcdnb_ctrl.sv]
// ----------------------------------------------------------------------------
// lcdnb_ctrl
// request decode, poll state and init progress; picks the phase script
// ----------------------------------------------------------------------------
module lcdnb_ctrl
    import lcdnb_pkg::*;
#(
    parameter int INIT_STEPS = INIT_STEPS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    lcdnb_req_if.sink i_req,
    input  logic     i_free,
    output logic     o_load,
    output t_script  o_script
);

    t_phase                r_phase,       n_phase;
    logic [7:0]            r_held_byte,   n_held_byte;
    logic                  r_held_select, n_held_select;
    logic [INIT_IDX_W-1:0] r_init_index,  n_init_index;
    logic                  r_init_active, n_init_active;

    logic                  accept;
    logic                  init_more;
    logic [INIT_IDX_W-1:0] next_index;

    assign i_req.ready = i_free;
    assign accept      = i_req.valid && i_free;
    assign o_load      = accept;
    assign next_index  = r_init_index + INIT_IDX_W'(1);
    assign init_more   = ({1'b0, r_init_index} + (INIT_IDX_W+1)'(1))
                         < (INIT_IDX_W+1)'(INIT_STEPS);

    // next state
    always_comb begin
        n_phase       = r_phase;
        n_held_byte   = r_held_byte;
        n_held_select = r_held_select;
        n_init_index  = r_init_index;
        n_init_active = r_init_active;
        case (r_phase)
            PH_IDLE: begin
                case (i_req.func)
                    FUNC_WRITE: begin
                        n_held_byte   = i_req.data_byte;
                        n_held_select = i_req.reg_select;
                        n_phase       = PH_WAIT;
                    end
                    FUNC_INIT: begin
                        n_init_active = 1'b1;
                        n_init_index  = '0;
                        n_held_byte   = table_byte('0);
                        n_held_select = 1'b0;
                        n_phase       = PH_WAIT;
                    end
                    default: n_phase = PH_IDLE;
                endcase
            end
            PH_WAIT: begin
                if (i_req.func == FUNC_SAMPLE && !i_req.busy_flag) begin
                    n_phase = PH_IDLE;
                    if (r_init_active) begin
                        if (init_more) begin
                            n_init_index  = next_index;
                            n_held_byte   = table_byte(next_index);
                            n_held_select = 1'b0;
                            n_phase       = PH_WAIT;
                        end else begin
                            n_init_active = 1'b0;
                            n_init_index  = '0;
                        end
                    end
                end
            end
            default: n_phase = PH_IDLE;
        endcase
    end

    // script for this word
    always_comb begin
        o_script        = '0;
        o_script.kind   = K_REJECT;
        o_script.wr_byte = r_held_byte;
        o_script.wr_sel = r_held_select;
        case (r_phase)
            PH_IDLE: begin
                if (i_req.func == FUNC_WRITE || i_req.func == FUNC_INIT) begin
                    o_script.kind = K_START;
                end else begin
                    o_script.rj_rs  = r_held_select;
                    o_script.rj_nib = r_held_byte[3:0];
                    o_script.rj_drv = 1'b1;
                end
            end
            PH_WAIT: begin
                if (i_req.func == FUNC_SAMPLE) begin
                    if (i_req.busy_flag) begin
                        o_script.kind = K_BUSY;
                    end else begin
                        o_script.kind = K_CLEAR;
                        o_script.more = r_init_active && init_more;
                    end
                end else begin
                    o_script.rj_rw = 1'b1;
                end
            end
            default: o_script.kind = K_REJECT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_held_byte   <= '0;
            r_held_select <= 1'b0;
            r_init_index  <= '0;
            r_init_active <= 1'b0;
        end else if (accept) begin
            r_phase       <= n_phase;
            r_held_byte   <= n_held_byte;
            r_held_select <= n_held_select;
            r_init_index  <= n_init_index;
            r_init_active <= n_init_active;
        end
    end

endmodule

[src/lcdnb_emit.sv]
// ----------------------------------------------------------------------------
// lcdnb_emit
// walks the loaded phase script, one pin phase word per cycle while o_pin
// is not stalled, into the output register
// ----------------------------------------------------------------------------
module lcdnb_emit
    import lcdnb_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_load,
    input  t_script      i_script,
    output logic         o_free,
    lcdnb_pin_if.source  o_pin
);

    logic                r_busy;
    t_script             r_script;
    logic [PH_IDX_W-1:0] r_idx;
    logic                r_ovalid;
    t_pins               r_out;

    logic                step;
    logic                at_last;
    t_pins               cur;

    assign step    = r_busy && (!r_ovalid || o_pin.ready);
    assign at_last = (r_idx == script_len(r_script) - PH_IDX_W'(1));
    assign o_free  = !r_busy || (step && at_last);

    always_comb begin
        cur      = phase_gen(r_script, r_idx);
        cur.last = at_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_idx    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_load) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (step) begin
                r_busy <= !at_last;
                r_idx  <= r_idx + PH_IDX_W'(1);
            end
            if (step) begin
                r_ovalid <= 1'b1;
            end else if (o_pin.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_script <= i_script;
        end
        if (step) begin
            r_out <= cur;
        end
    end

    assign o_pin.valid          = r_ovalid;
    assign o_pin.rs_pin         = r_out.rs_pin;
    assign o_pin.rw_pin         = r_out.rw_pin;
    assign o_pin.en_pin         = r_out.en_pin;
    assign o_pin.nibble_out     = r_out.nibble_out;
    assign o_pin.d7_drive       = r_out.d7_drive;
    assign o_pin.sample_request = r_out.sample_request;
    assign o_pin.last           = r_out.last;
    assign o_pin.rejected       = r_out.rejected;

endmodule

[src/char_lcd_nibble_bus_sequencer_unit.sv]
// ----------------------------------------------------------------------------
// char_lcd_nibble_bus_sequencer_unit
// hd44780 4-bit bus sequencer at the level of pin phases
// ----------------------------------------------------------------------------
// Each accepted request word yields a burst of pin phase words on o_pin, one
// per cycle while the sink is ready: 1 for a refused request, 3 for a write or
// init request (read set-up and the first busy poll pulse), 4 for a busy
// sample, 8 for a clear sample and 11 when an init sequence goes on to its
// next poll. The phase counter in the emitter paces the requests: a new one is
// taken in the cycle the last phase of the previous one enters the output
// register, not earlier. After a phase with sample_request set, return D7 as a
// sample word (func 2).
// ----------------------------------------------------------------------------
module char_lcd_nibble_bus_sequencer_unit
    import lcdnb_pkg::*;
#(
    parameter int INIT_STEPS = INIT_STEPS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lcdnb_req_if.sink   i_req,
    lcdnb_pin_if.source o_pin
);

    logic    free;
    logic    load;
    t_script script;

    lcdnb_ctrl #(
        .INIT_STEPS (INIT_STEPS)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_free   (free),
        .o_load   (load),
        .o_script (script)
    );

    lcdnb_emit u_emit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (load),
        .i_script (script),
        .o_free   (free),
        .o_pin    (o_pin)
    );

endmodule

[bench/char_lcd_nibble_bus_sequencer_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_nibble_bus_sequencer_unit_tb
// self-checking bench for the lcd nibble bus sequencer: a directed table of
// request words, then busy-poll and init sequences with random content, with
// each pin phase word checked in order against a behavioral predictor, or
// against the expected word that a typed table row gives
module char_lcd_nibble_bus_sequencer_unit_tb;
    import lcdnb_pkg::*;

    localparam int CLK_HALF   = 4;
    localparam int RST_CYCLES = 9;
    localparam int HANG_LIMIT = 4000;
    localparam int TAIL_WAIT  = 30;
    localparam int HOLD_OFF   = 80;
    localparam int RAND_ITEMS = 95;
    localparam int DIR_ROWS   = 25;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    // typed rejections: rs, rw, en, nibble, d7 drive, sample, last, rejected
    localparam t_pins RJ_IDLE_RST  = t_pins'{1'b0, 1'b0, 1'b0, 4'h0, 1'b1, 1'b0, 1'b1, 1'b1};
    localparam t_pins RJ_WAIT      = t_pins'{1'b0, 1'b1, 1'b0, 4'h0, 1'b0, 1'b0, 1'b1, 1'b1};
    localparam t_pins RJ_IDLE_FF   = t_pins'{1'b1, 1'b0, 1'b0, 4'hF, 1'b1, 1'b0, 1'b1, 1'b1};
    localparam t_pins RJ_IDLE_INIT = t_pins'{1'b0, 1'b0, 1'b0, 4'h1, 1'b1, 1'b0, 1'b1, 1'b1};
    localparam t_pins NO_WORD      = '0;

    typedef struct {
        logic [1:0] f;
        logic [7:0] d;
        logic       s;
        logic       b;
        bit         typed;
        t_pins      want;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    lcdnb_req_if req_ch ();
    lcdnb_pin_if pin_ch ();

    char_lcd_nibble_bus_sequencer_unit uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch),
        .o_pin  (pin_ch)
    );

    // predictor state
    t_phase     bus_state;
    logic [7:0] latched_byte;
    logic       latched_sel;
    logic [2:0] init_step;
    logic       init_on;

    t_pins phases_due [$];
    t_pins next_burst [$];

    int mismatches   = 0;
    int send_idle    = 0;
    int recv_idle    = 0;
    int hold_cnt     = 0;
    bit hold_req     = 1'b0;
    int quiet_cycles = 0;

    t_row plan [DIR_ROWS] = '{
        '{FUNC_SAMPLE, 8'h00, 1'b0, 1'b1, 1'b1, RJ_IDLE_RST},
        '{FUNC_UNUSED, 8'h00, 1'b0, 1'b0, 1'b1, RJ_IDLE_RST},
        '{FUNC_WRITE,  8'hFF, 1'b1, 1'b0, 1'b0, NO_WORD},
        '{FUNC_WRITE,  8'h5A, 1'b0, 1'b0, 1'b1, RJ_WAIT},
        '{FUNC_INIT,   8'h00, 1'b1, 1'b1, 1'b1, RJ_WAIT},
        '{FUNC_UNUSED, 8'hFF, 1'b1, 1'b1, 1'b1, RJ_WAIT},
        '{FUNC_SAMPLE, 8'h00, 1'b0, 1'b1, 1'b0, NO_WORD},
        '{FUNC_SAMPLE, 8'hFF, 1'b1, 1'b0, 1'b0, NO_WORD},
        '{FUNC_SAMPLE, 8'h00, 1'b0, 1'b0, 1'b1, RJ_IDLE_FF},
        '{FUNC_WRITE,  8'h00, 1'b0, 1'b1, 1'b0, NO_WORD},
        '{FUNC_SAMPLE, 8'h00, 1'b0, 1'b0, 1'b0, NO_WORD},
        '{FUNC_SAMPLE, 8'hFF, 1'b1, 1'b1, 1'b1, RJ_IDLE_RST},
        '{FUNC_WRITE,  8'hA5, 1'b1, 1'b0, 1'b0, NO_WORD},
        '{FUNC_SAMPLE, 8'h00, 1'b0, 1'b1, 1'b0, NO_WORD},
        '{FUNC_SAMPLE, 8'h00, 1'b0, 1'b1, 1'b0, NO_WORD},
        '{FUNC_SAMPLE, 8'h00, 1'b0, 1'b0, 1'b0, NO_WORD},
        '{FUNC_INIT,   8'hC3, 1'b1, 1'b0, 1'b0, NO_WORD},
        '{FUNC_SAMPLE, 8'h00, 1'b0, 1'b0, 1'b0, NO_WORD},
        '{FUNC_SAMPLE, 8'h00, 1'b0, 1'b1, 1'b0, NO_WORD},
        '{FUNC_SAMPLE, 8'h00, 1'b0, 1'b0, 1'b0, NO_WORD},
        '{FUNC_SAMPLE, 8'h00, 1'b0, 1'b0, 1'b0, NO_WORD},
        '{FUNC_SAMPLE, 8'h00, 1'b0, 1'b0, 1'b0, NO_WORD},
        '{FUNC_SAMPLE, 8'h00, 1'b0, 1'b0, 1'b0, NO_WORD},
        '{FUNC_SAMPLE, 8'h00, 1'b0, 1'b0, 1'b0, NO_WORD},
        '{FUNC_SAMPLE, 8'h00, 1'b0, 1'b1, 1'b1, RJ_IDLE_INIT}
    };

    initial i_clk = 1'b0;
    always #CLK_HALF i_clk = ~i_clk;

    function automatic logic [7:0] init_byte(input logic [2:0] idx);
        return (idx < TABLE_LEN) ? INIT_TABLE[idx] : INIT_TABLE[TABLE_LEN-1];
    endfunction

    function automatic void add_phase(input logic rs, input logic rw, input logic en,
                                      input logic [3:0] nib, input logic drv,
                                      input logic samp, input logic rej);
        t_pins w;
        w                = '0;
        w.rs_pin         = rs;
        w.rw_pin         = rw;
        w.en_pin         = en;
        w.nibble_out     = nib;
        w.d7_drive       = drv;
        w.sample_request = samp;
        w.rejected       = rej;
        next_burst.push_back(w);
    endfunction

    // read set-up and first read pulse of a busy poll
    function automatic void poll_start();
        add_phase(1'b0, 1'b1, 1'b0, 4'h0, 1'b0, 1'b0, 1'b0);
        add_phase(1'b0, 1'b1, 1'b1, 4'h0, 1'b0, 1'b0, 1'b0);
        add_phase(1'b0, 1'b1, 1'b0, 4'h0, 1'b0, 1'b1, 1'b0);
        bus_state = PH_WAIT;
    endfunction

    function automatic void nibble_write(input logic [3:0] nib);
        add_phase(latched_sel, 1'b0, 1'b0, nib, 1'b1, 1'b0, 1'b0);
        add_phase(latched_sel, 1'b0, 1'b1, nib, 1'b1, 1'b0, 1'b0);
        add_phase(latched_sel, 1'b0, 1'b0, nib, 1'b1, 1'b0, 1'b0);
    endfunction

    function automatic void predict_phases(input logic [1:0] f, input logic [7:0] d,
                                           input logic s, input logic b);
        t_pins w;
        next_burst.delete();
        if (bus_state == PH_IDLE && f == FUNC_WRITE) begin
            latched_byte = d;
            latched_sel  = s;
            poll_start();
        end else if (bus_state == PH_IDLE && f == FUNC_INIT) begin
            init_on      = 1'b1;
            init_step    = 3'd0;
            latched_byte = init_byte(3'd0);
            latched_sel  = 1'b0;
            poll_start();
        end else if (bus_state == PH_WAIT && f == FUNC_SAMPLE) begin
            // ignored low-nibble read pulse
            add_phase(1'b0, 1'b1, 1'b1, 4'h0, 1'b0, 1'b0, 1'b0);
            add_phase(1'b0, 1'b1, 1'b0, 4'h0, 1'b0, 1'b0, 1'b0);
            if (b) begin
                add_phase(1'b0, 1'b1, 1'b1, 4'h0, 1'b0, 1'b0, 1'b0);
                add_phase(1'b0, 1'b1, 1'b0, 4'h0, 1'b0, 1'b1, 1'b0);
            end else begin
                nibble_write(latched_byte[7:4]);
                nibble_write(latched_byte[3:0]);
                bus_state = PH_IDLE;
                if (init_on) begin
                    if (int'(init_step) + 1 < INIT_STEPS_DEF) begin
                        init_step    = init_step + 3'd1;
                        latched_byte = init_byte(init_step);
                        latched_sel  = 1'b0;
                        poll_start();
                    end else begin
                        init_on   = 1'b0;
                        init_step = 3'd0;
                    end
                end
            end
        end else if (bus_state == PH_WAIT) begin
            add_phase(1'b0, 1'b1, 1'b0, 4'h0, 1'b0, 1'b0, 1'b1);
        end else begin
            add_phase(latched_sel, 1'b0, 1'b0, latched_byte[3:0], 1'b1, 1'b0, 1'b1);
        end
        w      = next_burst.pop_back();
        w.last = 1'b1;
        next_burst.push_back(w);
    endfunction

    // offer one request word, starting and ending at a falling edge
    task automatic issue_request(input logic [1:0] f, input logic [7:0] d, input logic s,
                                 input logic b, input bit typed, input t_pins want);
        while ($urandom_range(99) < send_idle) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.func       <= f;
        req_ch.data_byte  <= d;
        req_ch.reg_select <= s;
        req_ch.busy_flag  <= b;
        do @(posedge i_clk); while (!req_ch.ready);
        predict_phases(f, d, s, b);
        if (typed) begin
            phases_due.push_back(want);
        end else begin
            phases_due = {phases_due, next_burst};
        end
        @(negedge i_clk);
    endtask

    // mostly well-formed poll and init traffic, some noise words
    task automatic run_random(input int count);
        int         r;
        logic [1:0] f;
        logic       b;
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(99);
            b = 1'($urandom_range(1));
            if (bus_state == PH_IDLE) begin
                if (r < 60)      f = FUNC_WRITE;
                else if (r < 75) f = FUNC_INIT;
                else if (r < 88) f = FUNC_SAMPLE;
                else             f = FUNC_UNUSED;
            end else begin
                if (r < 88) begin
                    f = FUNC_SAMPLE;
                    b = ($urandom_range(99) < 40);
                end else if (r < 92) begin
                    f = FUNC_WRITE;
                end else if (r < 96) begin
                    f = FUNC_INIT;
                end else begin
                    f = FUNC_UNUSED;
                end
            end
            issue_request(f, 8'($urandom_range(255)), 1'($urandom_range(1)), b, 1'b0,
                          NO_WORD);
        end
    endtask

    // pin word receiver with optional long hold-off
    always begin
        @(negedge i_clk);
        if (hold_cnt > 0) begin
            pin_ch.ready <= 1'b0;
            hold_cnt = hold_cnt - 1;
        end else if (hold_req) begin
            hold_req = 1'b0;
            hold_cnt = HOLD_OFF - 1;
            pin_ch.ready <= 1'b0;
        end else begin
            pin_ch.ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge i_clk) begin
        t_pins got;
        t_pins want;
        if (i_rst_n && pin_ch.valid && pin_ch.ready) begin
            got = t_pins'{pin_ch.rs_pin, pin_ch.rw_pin, pin_ch.en_pin, pin_ch.nibble_out,
                          pin_ch.d7_drive, pin_ch.sample_request, pin_ch.last,
                          pin_ch.rejected};
            if (phases_due.size() == 0) begin
                $error("pin word %h with no word expected", got);
                mismatches++;
            end else begin
                want = phases_due.pop_front();
                if (got.rs_pin != want.rs_pin) begin
                    $error("rs_pin: expected %0d, got %0d", want.rs_pin, got.rs_pin);
                    mismatches++;
                end
                if (got.rw_pin != want.rw_pin) begin
                    $error("rw_pin: expected %0d, got %0d", want.rw_pin, got.rw_pin);
                    mismatches++;
                end
                if (got.en_pin != want.en_pin) begin
                    $error("en_pin: expected %0d, got %0d", want.en_pin, got.en_pin);
                    mismatches++;
                end
                if (got.nibble_out != want.nibble_out) begin
                    $error("nibble_out: expected %h, got %h", want.nibble_out,
                           got.nibble_out);
                    mismatches++;
                end
                if (got.d7_drive != want.d7_drive) begin
                    $error("d7_drive: expected %0d, got %0d", want.d7_drive, got.d7_drive);
                    mismatches++;
                end
                if (got.sample_request != want.sample_request) begin
                    $error("sample_request: expected %0d, got %0d", want.sample_request,
                           got.sample_request);
                    mismatches++;
                end
                if (got.last != want.last) begin
                    $error("last: expected %0d, got %0d", want.last, got.last);
                    mismatches++;
                end
                if (got.rejected != want.rejected) begin
                    $error("rejected: expected %0d, got %0d", want.rejected, got.rejected);
                    mismatches++;
                end
            end
        end
    end

    // watchdog on cycles with no word moving on either channel
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (pin_ch.valid && pin_ch.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
        end
        if (quiet_cycles >= HANG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        i_rst_n           = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.func       = FUNC_WRITE;
        req_ch.data_byte  = 8'h00;
        req_ch.reg_select = 1'b0;
        req_ch.busy_flag  = 1'b0;
        pin_ch.ready      = 1'b0;
        bus_state         = PH_IDLE;
        latched_byte      = 8'h00;
        latched_sel       = 1'b0;
        init_step         = 3'd0;
        init_on           = 1'b0;

        repeat (RST_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_idle = 35;
        recv_idle = 73;
        for (int k = 0; k < DIR_ROWS; k++) begin
            issue_request(plan[k].f, plan[k].d, plan[k].s, plan[k].b, plan[k].typed,
                          plan[k].want);
        end
        run_random(RAND_ITEMS);

        send_idle = 73;
        recv_idle = 35;
        run_random(RAND_ITEMS);

        // sender keeps pushing while the receiver holds off
        send_idle = 0;
        recv_idle = 0;
        hold_req  = 1'b1;
        run_random(RAND_ITEMS);

        req_ch.valid <= 1'b0;
        while (phases_due.size() != 0) @(posedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
